/* design/ncsc_pkg.sv */
package ncsc_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DW = 32;
  localparam int MW = 48;
  localparam int IFRAC = 24;
  localparam int WW = MW + 8;

  localparam logic [MW-1:0] MAXM = {1'b0, {(MW-1){1'b1}}};

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;
  localparam logic [1:0] ST_DROP = 2'd3;

endpackage

/* design/ncsc_ram.sv */
module ncsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/natural_cubic_spline_coefficients_unit.sv */
// Points load at one word per cycle while in_ready is high; after the word marked last, the solve is
// paced by the shared 72-step restoring divider (three divisions per interior row) and the
// multiplier that sums four 24x24 partial products; each result word is then held until it is taken.
// Throughput: one data set at a time; input is not taken between the last point and the last result.
// Reset clears the sequencer, point count and error flags; the point stores are not cleared.
module natural_cubic_spline_coefficients_unit #(
  parameter int MAX_POINTS = ncsc_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS = ncsc_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] x_value,
  input  logic [31:0] y_value,
  input  logic        last_point,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  point_index,
  output logic [31:0] second_deriv,
  output logic [31:0] spacing,
  output logic [1:0]  status,
  output logic        last_result
);

  localparam int DW = ncsc_pkg::DW;
  localparam int MW = ncsc_pkg::MW;
  localparam int WW = ncsc_pkg::WW;
  localparam int IFR = ncsc_pkg::IFRAC;
  localparam int QW = MW + IFR;
  localparam int HW = MW / 2;
  localparam int DCW = $clog2(QW);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SH = IFR - FRAC_BITS;
  localparam logic [MW-1:0] MAXM = ncsc_pkg::MAXM;
  localparam logic signed [WW-1:0] SMAX = {{(WW-MW+1){1'b0}}, {(MW-1){1'b1}}};
  localparam logic signed [WW-1:0] SMIN = ~SMAX;
  localparam logic signed [MW:0] OMAX = {{(MW-DW+2){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [MW:0] OMIN = ~OMAX;

  typedef enum logic [27:0] {
    S_LOAD   = 28'h0000001,
    S_START  = 28'h0000002,
    S_RDW    = 28'h0000004,
    S_FX0    = 28'h0000008,
    S_FFETCH = 28'h0000010,
    S_FH     = 28'h0000020,
    S_FS     = 28'h0000040,
    S_FP     = 28'h0000080,
    S_FD     = 28'h0000100,
    S_FU     = 28'h0000200,
    S_FADV   = 28'h0000400,
    S_FEND   = 28'h0000800,
    S_BFETCH = 28'h0001000,
    S_BH     = 28'h0002000,
    S_BT     = 28'h0004000,
    S_BQ     = 28'h0008000,
    S_OSTART = 28'h0010000,
    S_OX0    = 28'h0020000,
    S_OFETCH = 28'h0040000,
    S_OD     = 28'h0080000,
    S_OEMIT  = 28'h0100000,
    S_OWAIT  = 28'h0200000,
    S_DSETUP = 28'h0400000,
    S_DSTEP  = 28'h0800000,
    S_DFIN   = 28'h1000000,
    S_MSETUP = 28'h2000000,
    S_MSTEP  = 28'h4000000,
    S_MFIN   = 28'h8000000
  } state_t;

  function automatic logic [MW:0] sat_m(input logic signed [WW-1:0] v);
    logic [MW:0] r;
    if (v > SMAX) begin
      r = {1'b1, MAXM};
    end else if (v < SMIN) begin
      r = {1'b1, ~MAXM};
    end else begin
      r = {1'b0, v[MW-1:0]};
    end
    return r;
  endfunction

  function automatic logic [DW:0] sat32(input logic signed [MW:0] v);
    logic [DW:0] r;
    if (v > OMAX) begin
      r = {1'b1, OMAX[DW-1:0]};
    end else if (v < OMIN) begin
      r = {1'b1, OMIN[DW-1:0]};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

  function automatic logic [WW-1:0] sx(input logic [MW-1:0] v);
    return {{(WW-MW){v[MW-1]}}, v};
  endfunction

  function automatic logic [MW:0] widen(input logic [DW:0] d);
    logic [WW-1:0] e;
    e = {{(WW-DW-1){d[DW]}}, d};
    return sat_m($signed(e <<< SH));
  endfunction

  function automatic logic [MW-1:0] mag(input logic [MW-1:0] v);
    return v[MW-1] ? (~v + 1'b1) : v;
  endfunction

  state_t state, ret;

  logic [CW-1:0] count, n1, i;
  logic          err, zgap;
  logic [DW-1:0] last_x;
  logic [AW-1:0] ra;

  logic          xy_we, p_we, d_we;
  logic [AW-1:0] xy_wa, p_wa, d_wa;
  logic [DW-1:0] xw_d, yw_d;
  logic [MW:0]   p_wd;
  logic [MW-1:0] d_wd;
  logic [DW-1:0] rdx, rdy;
  logic [MW:0]   rdp;
  logic [MW-1:0] rdd;

  logic [DW-1:0] x0, y0, x1, y1;
  logic [MW-1:0] h, hprev, u, s_prev, s_cur, dprev, piv, dcur, dnext, dk;
  logic          fl_row, fl_next, fk;

  logic [MW-1:0]  num_r, den_r, ub, rem, dres;
  logic [QW-1:0]  dvd, q;
  logic [DCW-1:0] dcnt;
  logic           dneg, dflag;

  logic [MW-1:0]   ma, mb, mua, mub, pp, mres;
  logic [2*MW-1:0] acc;
  logic [2:0]      mcnt;
  logic            mneg, mflag;

  logic [DW:0]     dx_f, dy_f, dx_b, dsp;
  logic [MW:0]     fhw, fdyw, bhw, pc1, pc2, dc1, dc2, tc, dsv;
  logic [MW-1:0]   dsel, dm, rem_s, qm, mm;
  logic [DW:0]     oc, sc;
  logic            ge, qov, mov, forced, has_next;
  logic [HW-1:0]   pa, pb;
  logic [2*MW-1:0] pps;

  assign in_ready = (state == S_LOAD);
  assign n1 = count - 1'b1;

  ncsc_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk(clk), .we(xy_we), .waddr(xy_wa), .wdata(xw_d), .raddr(ra), .rdata(rdx)
  );
  ncsc_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk(clk), .we(xy_we), .waddr(xy_wa), .wdata(yw_d), .raddr(ra), .rdata(rdy)
  );
  ncsc_ram #(.WIDTH(MW + 1), .DEPTH(MAX_POINTS)) u_piv_ram (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(ra), .rdata(rdp)
  );
  ncsc_ram #(.WIDTH(MW), .DEPTH(MAX_POINTS)) u_der_ram (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(ra), .rdata(rdd)
  );

  always_comb begin
    dx_f = {rdx[DW-1], rdx} - {x0[DW-1], x0};
    dy_f = {rdy[DW-1], rdy} - {y0[DW-1], y0};
    dx_b = {x0[DW-1], x0} - {rdx[DW-1], rdx};
    fhw = widen(dx_f);
    fdyw = widen(dy_f);
    bhw = widen(dx_b);
    pc1 = sat_m($signed((sx(hprev) + sx(h)) << 1));
    pc2 = sat_m($signed(sx(pc1[MW-1:0]) - sx(mres)));
    dc1 = sat_m($signed(sx(s_cur) - sx(s_prev)));
    dc2 = sat_m($signed(sx(dc1[MW-1:0]) - sx(mres)));
    tc = sat_m($signed((sx(dcur) << 2) + (sx(dcur) << 1) - sx(mres)));

    forced = zgap || (i == '0) || (i == n1);
    dsel = forced ? '0 : dk;
    dm = mag(dsel) >> SH;
    dsv = dsel[MW-1] ? (~{1'b0, dm} + 1'b1) : {1'b0, dm};
    oc = sat32($signed(dsv));
    dsp = {rdx[DW-1], rdx} - {x0[DW-1], x0};
    sc = sat32($signed({{(MW-DW){dsp[DW]}}, dsp}));
    has_next = (i + 1'b1) < count;

    rem_s = {rem[MW-2:0], dvd[QW-1]};
    ge = (rem_s >= ub);
    qov = |q[QW-1:MW-1];
    qm = qov ? MAXM : q[MW-1:0];

    pa = mcnt[1] ? mua[MW-1:HW] : mua[HW-1:0];
    pb = mcnt[0] ? mub[MW-1:HW] : mub[HW-1:0];
    case (mcnt)
      3'd1: pps = {{MW{1'b0}}, pp};
      3'd2, 3'd3: pps = {{MW{1'b0}}, pp} << HW;
      3'd4: pps = {{MW{1'b0}}, pp} << (2 * HW);
      default: pps = '0;
    endcase
    mov = |acc[2*MW-1:IFR+MW-1];
    mm = mov ? MAXM : acc[IFR+MW-1:IFR];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xy_we <= 1'b0;
      p_we <= 1'b0;
      d_we <= 1'b0;
    end else begin
      xy_we <= (state == S_LOAD) && in_valid && (count < CW'(MAX_POINTS));
      p_we <= ((state == S_FS) && (i == '0)) || (state == S_FU) || (state == S_FEND) ||
              (state == S_BQ);
      d_we <= (state == S_FD) || (state == S_BQ);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      err <= 1'b0;
      zgap <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (count < CW'(MAX_POINTS)) begin
              xy_wa <= AW'(count);
              xw_d <= x_value;
              yw_d <= y_value;
              if (count != '0 && x_value == last_x) begin
                zgap <= 1'b1;
              end
              last_x <= x_value;
              count <= count + 1'b1;
            end else begin
              err <= 1'b1;
            end
            if (last_point) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          i <= '0;
          fl_row <= 1'b0;
          fl_next <= 1'b0;
          u <= '0;
          dprev <= '0;
          if (zgap) begin
            state <= S_OSTART;
          end else if (n1 == '0) begin
            state <= S_FEND;
          end else begin
            ra <= '0;
            ret <= S_FX0;
            state <= S_RDW;
          end
        end
        S_RDW: state <= ret;
        S_FX0: begin
          x0 <= rdx;
          y0 <= rdy;
          state <= S_FFETCH;
        end
        S_FFETCH: begin
          ra <= AW'(i + 1'b1);
          ret <= S_FH;
          state <= S_RDW;
        end
        S_FH: begin
          x1 <= rdx;
          y1 <= rdy;
          h <= fhw[MW-1:0];
          fl_row <= fl_row | fhw[MW];
          fl_next <= fhw[MW] | fdyw[MW];
          num_r <= fdyw[MW-1:0];
          den_r <= fhw[MW-1:0];
          ret <= S_FS;
          state <= S_DSETUP;
        end
        S_FS: begin
          s_cur <= dres;
          fl_next <= fl_next | dflag;
          if (i == '0) begin
            p_wa <= AW'(i);
            p_wd <= {fl_row, {MW{1'b0}}};
            state <= S_FADV;
          end else begin
            ma <= u;
            mb <= hprev;
            ret <= S_FP;
            state <= S_MSETUP;
          end
        end
        S_FP: begin
          piv <= pc2[MW-1:0];
          fl_row <= fl_row | pc1[MW] | pc2[MW] | mflag;
          ma <= u;
          mb <= dprev;
          ret <= S_FD;
          state <= S_MSETUP;
        end
        S_FD: begin
          dprev <= dc2[MW-1:0];
          d_wa <= AW'(i);
          d_wd <= dc2[MW-1:0];
          fl_row <= fl_row | dc1[MW] | dc2[MW] | mflag;
          num_r <= h;
          den_r <= piv;
          ret <= S_FU;
          state <= S_DSETUP;
        end
        S_FU: begin
          u <= dres;
          p_wa <= AW'(i);
          p_wd <= {fl_row | dflag, piv};
          state <= S_FADV;
        end
        S_FADV: begin
          i <= i + 1'b1;
          x0 <= x1;
          y0 <= y1;
          hprev <= h;
          s_prev <= s_cur;
          fl_row <= fl_next;
          fl_next <= 1'b0;
          if ((i + 1'b1) < n1) begin
            state <= S_FFETCH;
          end else begin
            state <= S_FEND;
          end
        end
        S_FEND: begin
          p_wa <= AW'(i);
          p_wd <= {fl_row, {MW{1'b0}}};
          if (n1 >= CW'(2)) begin
            i <= n1 - 1'b1;
            dnext <= '0;
            state <= S_BFETCH;
          end else begin
            state <= S_OSTART;
          end
        end
        S_BFETCH: begin
          ra <= AW'(i);
          ret <= S_BH;
          state <= S_RDW;
        end
        S_BH: begin
          x1 <= rdx;
          h <= bhw[MW-1:0];
          piv <= rdp[MW-1:0];
          dcur <= rdd;
          fl_row <= rdp[MW] | bhw[MW];
          ma <= bhw[MW-1:0];
          mb <= dnext;
          ret <= S_BT;
          state <= S_MSETUP;
        end
        S_BT: begin
          fl_row <= fl_row | tc[MW] | mflag;
          num_r <= tc[MW-1:0];
          den_r <= piv;
          ret <= S_BQ;
          state <= S_DSETUP;
        end
        S_BQ: begin
          d_wa <= AW'(i);
          d_wd <= dres;
          p_wa <= AW'(i);
          p_wd <= {fl_row | dflag, piv};
          dnext <= dres;
          x0 <= x1;
          i <= i - 1'b1;
          if (i == CW'(1)) begin
            state <= S_OSTART;
          end else begin
            state <= S_BFETCH;
          end
        end
        S_OSTART: begin
          ra <= '0;
          ret <= S_OX0;
          state <= S_RDW;
        end
        S_OX0: begin
          x0 <= rdx;
          i <= '0;
          state <= S_OFETCH;
        end
        S_OFETCH: begin
          ra <= AW'(i);
          ret <= S_OD;
          state <= S_RDW;
        end
        S_OD: begin
          dk <= rdd;
          fk <= rdp[MW];
          ra <= AW'(i + 1'b1);
          ret <= S_OEMIT;
          state <= S_RDW;
        end
        S_OEMIT: begin
          x1 <= rdx;
          point_index <= 6'(i);
          second_deriv <= oc[DW-1:0];
          spacing <= has_next ? sc[DW-1:0] : '0;
          if (err) begin
            status <= ncsc_pkg::ST_DROP;
          end else if (zgap) begin
            status <= ncsc_pkg::ST_ZERO;
          end else if (fk || oc[DW] || (has_next && sc[DW])) begin
            status <= ncsc_pkg::ST_SAT;
          end else begin
            status <= ncsc_pkg::ST_OK;
          end
          last_result <= (i == n1);
          out_valid <= 1'b1;
          state <= S_OWAIT;
        end
        S_OWAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (i == n1) begin
              count <= '0;
              err <= 1'b0;
              zgap <= 1'b0;
              state <= S_LOAD;
            end else begin
              i <= i + 1'b1;
              x0 <= x1;
              state <= S_OFETCH;
            end
          end
        end
        S_DSETUP: begin
          if (den_r == '0) begin
            dres <= '0;
            dflag <= 1'b1;
            state <= ret;
          end else begin
            dvd <= {mag(num_r), {IFR{1'b0}}};
            ub <= mag(den_r);
            rem <= '0;
            q <= '0;
            dcnt <= DCW'(QW - 1);
            dneg <= num_r[MW-1] ^ den_r[MW-1];
            state <= S_DSTEP;
          end
        end
        S_DSTEP: begin
          rem <= ge ? (rem_s - ub) : rem_s;
          q <= {q[QW-2:0], ge};
          dvd <= {dvd[QW-2:0], 1'b0};
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          dres <= dneg ? (~qm + 1'b1) : qm;
          dflag <= qov;
          state <= ret;
        end
        S_MSETUP: begin
          mua <= mag(ma);
          mub <= mag(mb);
          mneg <= ma[MW-1] ^ mb[MW-1];
          acc <= '0;
          mcnt <= '0;
          state <= S_MSTEP;
        end
        S_MSTEP: begin
          if (mcnt != 3'd4) begin
            pp <= pa * pb;
          end
          if (mcnt != 3'd0) begin
            acc <= acc + pps;
          end
          mcnt <= mcnt + 1'b1;
          if (mcnt == 3'd4) begin
            state <= S_MFIN;
          end
        end
        S_MFIN: begin
          mres <= mneg ? (~mm + 1'b1) : mm;
          mflag <= mov;
          state <= ret;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result word is pending");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_point) |=> !in_ready)
    else $error("input still open after the last point");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_result) |=> (in_ready && count == '0))
    else $error("block did not return to loading after the final result");

endmodule

/* dv/tb_natural_cubic_spline_coefficients_unit.sv */
`timescale 1ns / 100ps

module tb_natural_cubic_spline_coefficients_unit;

  localparam int NPTS = 64;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int LONG_HOLD = 3000;
  localparam longint MAXV = 64'sh7FFF_FFFF_FFFF;
  localparam longint MINV = -64'sh8000_0000_0000;

  typedef struct {
    logic [5:0]  idx;
    logic [31:0] d2;
    logic [31:0] gap;
    logic [1:0]  st;
    logic        fin;
  } spline_word_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] x_value;
  logic [31:0] y_value;
  logic        last_point;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  point_index;
  logic [31:0] second_deriv;
  logic [31:0] spacing;
  logic [1:0]  status;
  logic        last_result;

  natural_cubic_spline_coefficients_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .x_value(x_value), .y_value(y_value), .last_point(last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_index(point_index), .second_deriv(second_deriv), .spacing(spacing),
    .status(status), .last_result(last_result)
  );

  spline_word_t expected_q[$];
  longint xs[NPTS], ys[NPTS], pivots[NPTS], derivs[NPTS];
  bit     row_sat[NPTS];
  int     held_points;
  bit     points_dropped;

  int  mismatches;
  int  words_in;
  int  words_out;
  int  sets_solved;
  int  cycles;
  int  hold_req;
  int  send_idle_pct;
  int  recv_idle_pct;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.", cycles, expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint sat48(longint v, inout bit f);
    if (v > MAXV) begin
      f = 1;
      return MAXV;
    end
    if (v < MINV) begin
      f = 1;
      return MINV;
    end
    return v;
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint widen(longint d, inout bit f);
    return sat48(d * 256, f);
  endfunction

  function automatic longint fix_mul(longint a, longint b, inout bit f);
    logic [95:0] p;
    logic [95:0] r;
    p = {32'b0, magnitude(a)} * {32'b0, magnitude(b)};
    r = p >> ncsc_pkg::IFRAC;
    if (r > MAXV) begin
      f = 1;
      r = MAXV;
    end
    return ((a < 0) != (b < 0)) ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  function automatic longint fix_div(longint a, longint b, inout bit f);
    logic [127:0] q;
    if (b == 0) begin
      f = 1;
      return 0;
    end
    q = ({64'b0, magnitude(a)} << ncsc_pkg::IFRAC) / {64'b0, magnitude(b)};
    if (q > MAXV) begin
      f = 1;
      q = MAXV;
    end
    return ((a < 0) != (b < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [31:0] clip32(longint v, inout bit f);
    if (v > 64'sh7FFF_FFFF) begin
      f = 1;
      v = 64'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      f = 1;
      v = -64'sh8000_0000;
    end
    return v[31:0];
  endfunction

  task automatic solve_tridiagonal(int n);
    int     last_row;
    longint u, v, w, t;
    last_row = n - 1;
    u = 0;
    derivs[0] = 0;
    for (int i = 0; i < last_row; i++) begin
      w = widen(xs[i+1] - xs[i], row_sat[i+1]);
      t = widen(ys[i+1] - ys[i], row_sat[i+1]);
      derivs[i+1] = fix_div(t, w, row_sat[i+1]);
    end
    w = last_row > 0 ? widen(xs[1] - xs[0], row_sat[0]) : 0;
    for (int i = 1; i < last_row; i++) begin
      v = w;
      w = widen(xs[i+1] - xs[i], row_sat[i]);
      t = sat48((v + w) * 2, row_sat[i]);
      pivots[i] = sat48(t - fix_mul(u, v, row_sat[i]), row_sat[i]);
      t = sat48(derivs[i+1] - derivs[i], row_sat[i]);
      derivs[i] = sat48(t - fix_mul(u, derivs[i-1], row_sat[i]), row_sat[i]);
      u = fix_div(w, pivots[i], row_sat[i]);
    end
    derivs[last_row] = 0;
    for (int i = last_row - 1; i > 0; i--) begin
      w = widen(xs[i+1] - xs[i], row_sat[i]);
      t = sat48(6 * derivs[i] - fix_mul(w, derivs[i+1], row_sat[i]), row_sat[i]);
      derivs[i] = fix_div(t, pivots[i], row_sat[i]);
    end
  endtask

  task automatic predict_point(logic [31:0] xv, logic [31:0] yv, logic fin);
    bit           zero_gap;
    bit           f;
    logic [63:0]  m;
    longint       d;
    spline_word_t r;
    if (held_points < NPTS) begin
      xs[held_points] = longint'(signed'(xv));
      ys[held_points] = longint'(signed'(yv));
      row_sat[held_points] = 0;
      held_points++;
    end else begin
      points_dropped = 1;
    end
    if (!fin) return;
    zero_gap = 0;
    for (int k = 0; k + 1 < held_points; k++)
      if (xs[k+1] == xs[k]) zero_gap = 1;
    if (zero_gap) begin
      for (int k = 0; k < held_points; k++) derivs[k] = 0;
    end else begin
      solve_tridiagonal(held_points);
    end
    for (int k = 0; k < held_points; k++) begin
      f = row_sat[k];
      d = derivs[k];
      m = magnitude(d) >> (ncsc_pkg::IFRAC - ncsc_pkg::FRAC_BITS_DEF);
      r.idx = k[5:0];
      r.d2 = clip32(d < 0 ? -longint'(m) : longint'(m), f);
      r.gap = (k + 1 < held_points) ? clip32(xs[k+1] - xs[k], f) : 32'd0;
      r.st = points_dropped ? ncsc_pkg::ST_DROP : zero_gap ? ncsc_pkg::ST_ZERO :
             f ? ncsc_pkg::ST_SAT : ncsc_pkg::ST_OK;
      r.fin = (k == held_points - 1);
      expected_q.push_back(r);
    end
    held_points = 0;
    points_dropped = 0;
    sets_solved++;
  endtask

  task automatic send_word(logic [31:0] xv, logic [31:0] yv, logic fin);
    int gap;
    @(negedge clk);
    x_value = xv;
    y_value = yv;
    last_point = fin;
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_point(xv, yv, fin);
    words_in++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_set(int n, int shape);
    logic [31:0] xv;
    logic [31:0] yv;
    int          dup_at;
    xv = $urandom();
    if (shape == 0) xv = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
    dup_at = $urandom_range(1, n > 1 ? n - 1 : 1);
    for (int k = 0; k < n; k++) begin
      yv = (shape == 0) ? $urandom_range(0, 32'h0010_0000) - 32'h0008_0000 : $urandom();
      send_word(xv, yv, k == n - 1);
      case (shape)
        0: xv = xv + $urandom_range(32'h0000_0100, 32'h0004_0000);
        1: xv = $urandom();
        default: xv = (k + 1 == dup_at) ? xv : xv + $urandom_range(1, 32'h0002_0000);
      endcase
    end
  endtask

  task automatic test_directed();
    send_word(32'h0001_0000, 32'h8000_0000, 1'b1);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_word(32'h8000_0000, 32'h0000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_word(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0001_0000, 32'h0001_0000, 1'b0);
    send_word(32'h0001_0000, 32'h0004_0000, 1'b0);
    send_word(32'h0003_0000, 32'hFFFF_0000, 1'b1);
    send_word(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0000_0001, 32'h7FFF_FFFF, 1'b0);
    send_word(32'h0000_0002, 32'h8000_0000, 1'b0);
    send_word(32'h0000_0003, 32'h0000_0000, 1'b1);
    send_word(32'h0005_0000, 32'h0002_0000, 1'b0);
    send_word(32'h0002_0000, 32'hFFFE_0000, 1'b0);
    send_word(32'hFFFF_8000, 32'h0001_8000, 1'b0);
    send_word(32'h0004_0000, 32'h0000_4000, 1'b1);
    wait_drained();
  endtask

  task automatic test_capacity();
    for (int k = 0; k < NPTS; k++)
      send_word(k * 32'h0001_0000, $urandom_range(0, 32'h0003_0000), k == NPTS - 1);
    for (int k = 0; k < NPTS + 2; k++)
      send_word(k * 32'h0000_8000, $urandom(), k == NPTS + 1);
    for (int k = 0; k < NPTS + 1; k++)
      send_word($urandom(), $urandom(), k == NPTS);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_set(3, 0);
    hold_req++;
    send_set(4, 0);
    send_set(2, 1);
    wait_drained();
  endtask

  task automatic test_random_sets(int item_goal);
    int r;
    while (words_in < item_goal) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 30;
        recv_idle_pct = 30;
      end
      r = $urandom_range(0, 99);
      send_set($urandom_range(0, 9) == 0 ? $urandom_range(9, 20) : $urandom_range(1, 8),
               r < 70 ? 0 : (r < 85 ? 1 : 2));
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
  endtask

  initial begin
    int stall;
    int hold_seen;
    hold_seen = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        out_ready = 0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
        out_ready = 0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready = 1;
      end
    end
  end

  always @(posedge clk) begin
    spline_word_t e;
    if (!rst && out_valid && out_ready) begin
      words_out++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: index %0d deriv %h", point_index, second_deriv);
      end else begin
        e = expected_q.pop_front();
        if (point_index !== e.idx || second_deriv !== e.d2 || spacing !== e.gap ||
            status !== e.st || last_result !== e.fin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp idx %0d d2 %h sp %h st %0d last %0b, got %0d %h %h %0d %0b",
                     e.idx, e.d2, e.gap, e.st, e.fin,
                     point_index, second_deriv, spacing, status, last_result);
        end
      end
    end
  end

  initial begin
    rst = 1;
    in_valid = 0;
    x_value = 0;
    y_value = 0;
    last_point = 0;
    hold_req = 0;
    send_idle_pct = 30;
    recv_idle_pct = 30;
    words_in = 0;
    sets_solved = 0;
    held_points = 0;
    points_dropped = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    test_directed();
    test_backpressure();
    test_capacity();
    test_random_sets(370);

    @(negedge clk);
    in_valid = 0;
    wait_drained();
    repeat (50) @(posedge clk);

    $display("Sent %0d points in %0d data sets and checked %0d result words.",
             words_in, sets_solved, words_out);
    $display("Covered extremes, zero spacing, overflow drops and long output stalls.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
